// File: rtl/saturating_running_average_assert.svh
// Assertion macros shared by the running average modules.
`ifndef SATURATING_RUNNING_AVERAGE_ASSERT_SVH
`define SATURATING_RUNNING_AVERAGE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sra_pkg.sv
// Shared constants, types and state encoding of the running average block.
package sra_pkg;

	localparam int SampleWidthDef = 24;
	localparam int CountWidthDef = 16;

	// Register reset values.
	localparam int LimitReset = 1000;
	localparam int StartReset = -1475;

	// Register indexes, decoded from address bit 2.
	localparam logic [0:0] RegCountLimit = 1'b0;
	localparam logic [0:0] RegStartAverage = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DIV,
		ST_DONE
	} sra_state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic add;
		logic div_step;
		logic finish;
	} sra_cmd_t;

	typedef struct packed {
		logic div_last;
	} sra_stat_t;

endpackage

// File: rtl/sra_if.sv
// Valid/ready channel interfaces for sensor items and result items.
interface sra_in_if #(
	parameter int SAMPLE_WIDTH = sra_pkg::SampleWidthDef
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           sensor_present;

	modport source (output valid, sample, sensor_present, input ready);
	modport sink (input valid, sample, sensor_present, output ready);
endinterface

interface sra_out_if #(
	parameter int SAMPLE_WIDTH = sra_pkg::SampleWidthDef,
	parameter int COUNT_WIDTH  = sra_pkg::CountWidthDef
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] average;
	logic [COUNT_WIDTH-1:0]         samples_counted;

	modport source (output valid, average, samples_counted, input ready);
	modport sink (input valid, average, samples_counted, output ready);
endinterface

// File: rtl/sra_ctrl.sv
// Sequencing state machine of the running average block.
`include "saturating_running_average_assert.svh"

module sra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sra_pkg::sra_stat_t stat,
	output sra_pkg::sra_cmd_t  cmd
);
	import sra_pkg::*;

	sra_state_t state_q;
	sra_state_t state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// The result waits here until the output register is free.
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`SRA_ASSERT_NEXT(a_load_starts_mul, cmd.load, state_q == ST_MUL, "load not followed by multiply")
	`SRA_ASSERT_NOW(a_finish_slot_free, cmd.finish, !out_valid_q || out_ready, "result overwritten")
	`SRA_ASSERT_NEXT(a_finish_shows_result, cmd.finish, out_valid_q, "finished result not shown")

endmodule

// File: rtl/sra_dp.sv
// Datapath: count update, multiply, accumulate and bit-serial signed division.
`include "saturating_running_average_assert.svh"

module sra_dp #(
	parameter int SAMPLE_WIDTH = sra_pkg::SampleWidthDef,
	parameter int COUNT_WIDTH  = sra_pkg::CountWidthDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sra_pkg::sra_cmd_t              cmd,
	output sra_pkg::sra_stat_t             stat,
	input  logic [COUNT_WIDTH-1:0]         count_limit,
	input  logic signed [SAMPLE_WIDTH-1:0] start_average,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           sensor_present,
	output logic signed [SAMPLE_WIDTH-1:0] average,
	output logic [COUNT_WIDTH-1:0]         samples_counted
);
	import sra_pkg::*;

	localparam int AccWidth  = SAMPLE_WIDTH + COUNT_WIDTH;
	localparam int DivWidth  = AccWidth - 1;
	localparam int StepWidth = $clog2(DivWidth);

	logic [COUNT_WIDTH-1:0]         count_q;
	logic signed [SAMPLE_WIDTH-1:0] avg_q;
	logic signed [SAMPLE_WIDTH-1:0] old_q;
	logic signed [SAMPLE_WIDTH-1:0] smp_q;
	logic [COUNT_WIDTH-1:0]         n_q;
	logic [COUNT_WIDTH-1:0]         nm1_q;
	logic signed [AccWidth-1:0]     prod_q;
	logic                           neg_q;
	logic [DivWidth-1:0]            quo_q;
	logic [COUNT_WIDTH-1:0]         rem_q;
	logic [StepWidth-1:0]           step_q;
	logic signed [SAMPLE_WIDTH-1:0] average_q;
	logic [COUNT_WIDTH-1:0]         counted_q;

	logic [COUNT_WIDTH-1:0]         lim;
	logic signed [SAMPLE_WIDTH-1:0] old_avg;
	logic                           bump;
	logic signed [AccWidth:0]       prod_full;
	logic signed [AccWidth-1:0]     acc;
	logic [AccWidth-1:0]            acc_mag;
	logic [COUNT_WIDTH:0]           trial;
	logic [COUNT_WIDTH:0]           diff;
	logic                           ge;
	logic                           hi_zero;
	logic signed [SAMPLE_WIDTH-1:0] res;

	// A zero limit behaves as a limit of one.
	assign lim     = (count_limit == '0) ? COUNT_WIDTH'(1) : count_limit;
	assign old_avg = (count_q == '0) ? start_average : avg_q;
	assign bump    = count_q < lim;

	assign prod_full = (AccWidth+1)'(old_q) * (AccWidth+1)'($signed({1'b0, nm1_q}));
	assign acc       = prod_q + AccWidth'(smp_q);
	assign acc_mag   = acc[AccWidth-1] ? AccWidth'(-acc) : AccWidth'(acc);

	assign trial = {rem_q, quo_q[DivWidth-1]};
	assign diff  = trial - {1'b0, n_q};
	assign ge    = trial >= {1'b0, n_q};

	// Saturate the signed quotient to the sample range.
	assign hi_zero = quo_q[DivWidth-1:SAMPLE_WIDTH-1] == '0;
	always_comb begin
		res = '0;
		if (neg_q) begin
			res = hi_zero ? -$signed(quo_q[SAMPLE_WIDTH-1:0])
				: {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			res = hi_zero ? $signed(quo_q[SAMPLE_WIDTH-1:0])
				: {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			avg_q   <= SAMPLE_WIDTH'(StartReset);
		end else begin
			if (cmd.load && bump) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.finish) begin
				avg_q <= res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			old_q <= old_avg;
			smp_q <= sensor_present ? sample : old_avg;
			n_q   <= bump ? count_q + 1'b1 : count_q;
			nm1_q <= bump ? count_q : count_q - 1'b1;
		end
		if (cmd.mul) begin
			prod_q <= $signed(prod_full[AccWidth-1:0]);
		end
		if (cmd.add) begin
			neg_q  <= acc[AccWidth-1];
			quo_q  <= acc_mag[DivWidth-1:0];
			rem_q  <= '0;
			step_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
			quo_q  <= {quo_q[DivWidth-2:0], ge};
			step_q <= step_q + 1'b1;
		end
		if (cmd.finish) begin
			average_q <= res;
			counted_q <= n_q;
		end
	end

	assign stat.div_last   = step_q == StepWidth'(DivWidth - 1);
	assign average         = average_q;
	assign samples_counted = counted_q;

	`SRA_ASSERT_NEXT(a_divisor_nonzero, cmd.load, n_q != '0 && n_q == count_q, "bad divisor")
	`SRA_ASSERT_NOW(a_rem_below_divisor, cmd.div_step, rem_q < n_q, "remainder not reduced")

endmodule

// File: rtl/saturating_running_average.sv
// Top level of the saturating running average: registers, controller and datapath.
//
//   channel  | direction | handshake      | payload
//   ---------+-----------+----------------+----------------------------------
//   sensor   | in        | valid / ready  | sample, sensor_present
//   result   | out       | valid / ready  | average, samples_counted
//   config   | in        | APB write/read | count_limit (0x0), start_average (0x4)
//
// An item passes from acceptance through multiply, accumulate and the bit-serial
// divider, which retires one quotient bit per cycle, to the output register.
// A new item is accepted in the cycle after the previous result has entered the
// output register, even while that result still waits there, so the block does
// not take a new item before it is through with the last one.
// A stalled output holds its result; the finished next result then waits in
// the datapath until the output register is free.
// Reset is asynchronous and active low; it clears the count, so the first item
// after reset takes start_average as the old average.

module saturating_running_average #(
	parameter int SAMPLE_WIDTH = sra_pkg::SampleWidthDef,
	parameter int COUNT_WIDTH  = sra_pkg::CountWidthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	sra_in_if.sink      sensor,
	sra_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sra_pkg::*;

	logic [COUNT_WIDTH-1:0]         count_limit_q;
	logic signed [SAMPLE_WIDTH-1:0] start_average_q;
	logic                           cfg_wr;
	logic [0:0]                     reg_idx;
	sra_cmd_t                       cmd;
	sra_stat_t                      stat;

	// The APB port never stalls. Registers sit at word addresses, so only
	// address bit 2 selects between them.
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_limit_q   <= COUNT_WIDTH'(LimitReset);
			start_average_q <= SAMPLE_WIDTH'(StartReset);
		end else if (cfg_wr) begin
			case (reg_idx)
				RegCountLimit: begin
					count_limit_q <= pwdata[COUNT_WIDTH-1:0];
				end
				RegStartAverage: begin
					start_average_q <= $signed(pwdata[SAMPLE_WIDTH-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// Read data: the limit is zero-extended, the start average sign-extended.
	always_comb begin
		case (reg_idx)
			RegCountLimit:   prdata = 32'(count_limit_q);
			RegStartAverage: prdata = 32'(start_average_q);
			default:         prdata = '0;
		endcase
	end

	// The controller sequences load, multiply, accumulate, the divider steps
	// and the hand-over to the output register.
	sra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sensor.valid),
		.in_ready  (sensor.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the running state, the product, the divider and the
	// output payload register.
	sra_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.count_limit     (count_limit_q),
		.start_average   (start_average_q),
		.sample          (sensor.sample),
		.sensor_present  (sensor.sensor_present),
		.average         (result.average),
		.samples_counted (result.samples_counted)
	);

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the saturating running average block.

typedef logic signed [sra_pkg::SampleWidthDef-1:0] current_t;
typedef logic [sra_pkg::CountWidthDef-1:0] count_t;

typedef struct packed {
	current_t average;
	count_t   samples_counted;
} average_result_t;

class average_tracker;
	count_t          limit;
	current_t        start_avg;
	current_t        running_avg;
	count_t          sample_cnt;
	average_result_t expected_averages[$];
	int unsigned     mismatches;
	int unsigned     results_checked;

	function new();
		limit = count_t'(sra_pkg::LimitReset);
		start_avg = current_t'(sra_pkg::StartReset);
		running_avg = start_avg;
		sample_cnt = '0;
		mismatches = 0;
		results_checked = 0;
	endfunction

	// Updates the average and count for one accepted item and queues the result.
	function void note_sample(current_t sample, logic present);
		current_t        old_avg;
		current_t        taken;
		count_t          eff_limit;
		longint          divisor;
		longint          weighted;
		longint          quotient;
		longint          top;
		average_result_t res;
		old_avg = (sample_cnt == 0) ? start_avg : running_avg;
		taken = present ? sample : old_avg;
		eff_limit = (limit == 0) ? count_t'(1) : limit;
		if (sample_cnt < eff_limit)
			sample_cnt = sample_cnt + 1'b1;
		divisor = 64'(sample_cnt);
		weighted = longint'(old_avg) * (divisor - 1) + longint'(taken);
		quotient = weighted / divisor;
		top = (longint'(1) <<< (sra_pkg::SampleWidthDef - 1)) - 1;
		if (quotient > top)
			quotient = top;
		if (quotient < -top - 1)
			quotient = -top - 1;
		running_avg = current_t'(quotient);
		res.average = running_avg;
		res.samples_counted = sample_cnt;
		expected_averages.push_back(res);
	endfunction

	function void check_result(current_t avg, count_t cnt);
		average_result_t want;
		results_checked++;
		if (expected_averages.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Unexpected result: average %0d count %0d", avg, cnt);
			return;
		end
		want = expected_averages.pop_front();
		if (avg !== want.average || cnt !== want.samples_counted) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Result %0d: expected average %0d count %0d, got average %0d count %0d",
					results_checked, want.average, want.samples_counted, avg, cnt);
		end
	endfunction
endclass

module tb;
	import sra_pkg::*;

	localparam int SampleW = SampleWidthDef;
	localparam int CountW = CountWidthDef;
	localparam current_t CurMax = {1'b0, {(SampleW-1){1'b1}}};
	localparam current_t CurMin = {1'b1, {(SampleW-1){1'b0}}};
	localparam count_t CountMax = '1;

	localparam int unsigned CycleLimit = 600000;
	localparam int unsigned RandomItems = 1950;
	localparam int unsigned RandomPhases = 8;
	localparam int unsigned IdlePercent = 14;
	localparam int unsigned HoldoffStart = 700;
	localparam int unsigned HoldoffCycles = 600;
	localparam int unsigned CalmFirst = 1200;
	localparam int unsigned CalmLast = 1500;
	localparam int unsigned DrainCycles = 60;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sra_in_if  sensor_ch ();
	sra_out_if result_ch ();

	average_tracker tracker = new();
	int unsigned    items_accepted = 0;
	int unsigned    cycle_count = 0;
	int unsigned    settings_used = 0;

	saturating_running_average u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.sensor  (sensor_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: stops the run with a failure once the cycle count reaches CycleLimit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// Random idling for either side; inside the calm window neither side idles, so
	// items flow back to back for a few hundred results.
	function automatic bit idles(int unsigned progress);
		return (progress < CalmFirst || progress >= CalmLast) && ($urandom_range(99) < IdlePercent);
	endfunction

	// Most random samples span the whole field so that every bit toggles; the rest sit
	// close to the extremes or near zero, where rounding towards zero matters most.
	function automatic current_t random_current();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick < 6)
			return current_t'($urandom);
		else if (pick == 6)
			return CurMax - current_t'($urandom_range(3));
		else if (pick == 7)
			return CurMin + current_t'($urandom_range(3));
		else
			return current_t'(int'($urandom_range(511)) - 256);
	endfunction

	// APB write: a setup cycle, then an access cycle that completes while pready is
	// high. The tracker takes the same value as the register, cut to its width.
	task automatic write_reg(input logic [0:0] index, input longint value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value[31:0];
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (index == RegCountLimit)
			tracker.limit = value[CountW-1:0];
		else
			tracker.start_avg = value[SampleW-1:0];
	endtask

	// Offers one sensor item and returns at the edge at which it is accepted. Valid
	// stays high on return, so a following item that does not idle goes out without a bubble.
	task automatic send_item(input current_t value, input logic present);
		while (idles(items_accepted)) begin
			sensor_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sensor_ch.valid <= 1'b1;
		sensor_ch.sample <= value;
		sensor_ch.sensor_present <= present;
		do @(posedge clk); while (!sensor_ch.ready);
		tracker.note_sample(value, present);
		items_accepted++;
	endtask

	// Stops offering and waits until every expected result has come back, so that the
	// block is idle before the registers are touched. Every item yields a result, so
	// only a short margin follows.
	task automatic wait_drained();
		sensor_ch.valid <= 1'b0;
		while (tracker.expected_averages.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Result side. It checks each accepted result against the oldest expectation and
	// then picks the next value of ready. Once enough results have come, it holds
	// ready low for a long stretch while the sender keeps offering, so the output
	// register and the datapath both fill and the block stops taking items.
	initial begin : result_sink
		int unsigned hold_left;
		bit          hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				tracker.check_result(result_ch.average, result_ch.samples_counted);
			if (!hold_done && tracker.results_checked >= HoldoffStart) begin
				hold_done = 1'b1;
				hold_left = HoldoffCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= !idles(tracker.results_checked);
			end
		end
	end

	initial begin : stimulus
		int unsigned p;
		count_t      lim;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sensor_ch.valid <= 1'b0;
		sensor_ch.sample <= '0;
		sensor_ch.sensor_present <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A zero limit acts as one, so each average equals its own sample. The first
		// item, with the sensor absent, must return the freshly written start value.
		write_reg(RegStartAverage, CurMax);
		write_reg(RegCountLimit, 0);
		settings_used++;
		send_item(current_t'(0), 1'b0);
		send_item(CurMax, 1'b1);
		send_item(CurMin, 1'b1);
		send_item(current_t'(0), 1'b1);
		send_item(current_t'(-1), 1'b1);
		send_item(random_current(), 1'b0);
		wait_drained();

		// A limit of one written explicitly behaves the same way.
		write_reg(RegCountLimit, 1);
		settings_used++;
		send_item(CurMin, 1'b1);
		send_item(CurMax, 1'b0);
		send_item(current_t'(1), 1'b1);
		wait_drained();

		// A small limit: the count climbs and then holds, with full-scale swings in
		// the samples and an absent sensor in between.
		write_reg(RegCountLimit, 4);
		settings_used++;
		send_item(CurMax, 1'b1);
		send_item(CurMax, 1'b1);
		send_item(CurMin, 1'b1);
		send_item(CurMin, 1'b0);
		send_item(CurMin, 1'b1);
		send_item(current_t'(-3), 1'b1);
		wait_drained();

		// The widest limit, and a start value that no longer has any effect.
		write_reg(RegStartAverage, CurMin);
		write_reg(RegCountLimit, CountMax);
		settings_used++;
		send_item(CurMin, 1'b1);
		send_item(CurMax, 1'b1);
		send_item(CurMax, 1'b0);
		send_item(current_t'(-1), 1'b1);
		send_item(CurMin, 1'b1);
		send_item(current_t'(7), 1'b1);

		// Random phases, each with its own limit and start value. Some limits lie
		// below the count already reached, where the count must hold its value.
		for (p = 0; p < RandomPhases; p++) begin
			wait_drained();
			case (p)
				0: lim = count_t'(2);
				1: lim = '0;
				2: lim = CountMax;
				3: lim = count_t'($urandom_range(64, 3));
				4: lim = count_t'($urandom_range(CountMax, 1));
				5: lim = (tracker.sample_cnt > 1) ?
					count_t'($urandom_range(tracker.sample_cnt - 1, 1)) : count_t'(1);
				6: lim = count_t'(LimitReset);
				default: lim = count_t'(1);
			endcase
			write_reg(RegCountLimit, lim);
			write_reg(RegStartAverage, random_current());
			settings_used++;
			repeat (RandomItems / RandomPhases)
				send_item(random_current(), $urandom_range(99) < 85);
		end

		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		$display("Covered %0d sensor items under %0d register settings; %0d results checked.",
			items_accepted, settings_used, tracker.results_checked);
		$display("Failed checks: %0d, results still awaited: %0d",
			tracker.mismatches, tracker.expected_averages.size());
		if (tracker.mismatches == 0 && tracker.expected_averages.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
